### hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_MODIFY = 2'd2,
    FN_CANCEL = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   item_id;
    logic [KEY_W-1:0]  item_key;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   out_id;
    logic [KEY_W-1:0]  out_key;
    logic [CNT_W-1:0]  entry_count;
    logic [SUM_W-1:0]  key_total;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
  } slot_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
  } cell_ctrl_t;

endpackage

### hw/rtl/sorted_priority_queue_with_cancel.sv
`timescale 1ns / 1ps
// Sorted priority queue with cancel: up to 64 (id, key) entries held in a
// row of cells in ascending key order, equal keys in arrival order.
// Command channel: cmd_i is taken at a rising edge with start_i high and
// busy_o low. cmd_i.func selects insert, pop smallest, modify key by id, or
// cancel by id.
// Result channel: one item per command on rsp_o, marked by done_o for
// exactly one cycle; the receiver cannot stall it, so it must take it then.
// Steps: in the exec state every cell runs the operation at once (compare
// and shift to the neighbor); the next cycle shows the result. Insert, pop
// and cancel run exec only; a successful modify runs exec, then reinsert
// (a delete step, then an insert step through the same cell row). busy_o
// drops in the cycle that done_o is high, so the next item may enter then.
// Every result carries the entry count and key sum after the operation.
// Reset clears the cell valid bits, the count, the key sum and the
// sequencer at once; no clearing pass is needed.
module sorted_priority_queue_with_cancel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  spq_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output spq_pkg::rsp_t rsp_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  spq_pkg::state_e            state_q, state_d;
  spq_pkg::cmd_t              cmd_q;
  logic [spq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [spq_pkg::SUM_W-1:0]  sum_q, sum_d;
  spq_pkg::rsp_t              rsp_q, rsp_d;
  logic                       done_q, done_d;

  spq_pkg::cell_ctrl_t        ctrl;
  logic                       hit_first;
  spq_pkg::slot_t             slots [N];
  spq_pkg::slot_t             picks [N];
  spq_pkg::slot_t             lefts [N];
  spq_pkg::slot_t             rights [N];
  logic                       gts [N];
  logic                       left_gts [N];
  logic                       hits [N+1];
  spq_pkg::slot_t             removed;

  logic full, empty, found, accept;

  assign accept = start_i && !busy_o;
  assign full   = (count_q == spq_pkg::CNT_W'(N));
  assign empty  = (count_q == '0);
  assign found  = hits[N];

  // neighbor wiring: cell 0 has nothing on its left, the last cell an empty right
  always_comb begin
    for (int i = 0; i < N; i++) begin
      lefts[i]    = (i == 0) ? '0 : slots[(i == 0) ? 0 : i - 1];
      left_gts[i] = (i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1];
      rights[i]   = (i == N - 1) ? '0 : slots[(i == N - 1) ? i : i + 1];
    end
  end

  assign hits[0] = hit_first;

  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (lefts[g]),
      .left_gt_i (left_gts[g]),
      .right_i   (rights[g]),
      .hit_i     (hits[g]),
      .hit_o     (hits[g+1]),
      .gt_o      (gts[g]),
      .slot_o    (slots[g]),
      .pick_o    (picks[g])
    );
  end

  // gather the first id match; pop always takes the head
  always_comb begin
    removed = '0;
    for (int i = 0; i < N; i++) begin
      removed = removed | picks[i];
    end
    if (cmd_q.func == spq_pkg::FN_POP) begin
      removed = slots[0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        if (cmd_q.func == spq_pkg::FN_MODIFY && found) begin
          state_d = spq_pkg::S_REINS;
        end else begin
          state_d = spq_pkg::S_IDLE;
        end
      end
      spq_pkg::S_REINS: state_d = spq_pkg::S_IDLE;
      default:          state_d = spq_pkg::S_IDLE;
    endcase
  end

  // outputs: cell commands, count and sum updates, result item
  always_comb begin
    ctrl      = '{op: spq_pkg::CELL_HOLD, id: cmd_q.item_id, key: cmd_q.item_key};
    hit_first = 1'b0;
    count_d   = count_q;
    sum_d     = sum_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      spq_pkg::S_EXEC: begin
        rsp_d.status  = spq_pkg::ST_OK;
        rsp_d.out_id  = '0;
        rsp_d.out_key = '0;
        done_d        = 1'b1;
        unique case (cmd_q.func)
          spq_pkg::FN_INSERT: begin
            if (full) begin
              rsp_d.status = spq_pkg::ST_FULL;
            end else begin
              ctrl.op       = spq_pkg::CELL_INSERT;
              count_d       = count_q + spq_pkg::CNT_W'(1);
              sum_d         = sum_q + spq_pkg::SUM_W'(cmd_q.item_key);
              rsp_d.out_id  = cmd_q.item_id;
              rsp_d.out_key = cmd_q.item_key;
            end
          end
          spq_pkg::FN_POP: begin
            if (empty) begin
              rsp_d.status = spq_pkg::ST_EMPTY;
            end else begin
              ctrl.op       = spq_pkg::CELL_DELETE;
              hit_first     = 1'b1;
              count_d       = count_q - spq_pkg::CNT_W'(1);
              sum_d         = sum_q - spq_pkg::SUM_W'(removed.key);
              rsp_d.out_id  = removed.id;
              rsp_d.out_key = removed.key;
            end
          end
          default: begin
            // modify and cancel both start by removing the first match
            ctrl.op = spq_pkg::CELL_DELETE;
            if (!found) begin
              rsp_d.status = spq_pkg::ST_NOTFOUND;
            end else begin
              count_d       = count_q - spq_pkg::CNT_W'(1);
              sum_d         = sum_q - spq_pkg::SUM_W'(removed.key);
              rsp_d.out_id  = removed.id;
              rsp_d.out_key = removed.key;
              // hold the result back until the reinsert step
              if (cmd_q.func == spq_pkg::FN_MODIFY) begin
                done_d = 1'b0;
              end
            end
          end
        endcase
        rsp_d.entry_count = count_d;
        rsp_d.key_total   = sum_d;
      end
      spq_pkg::S_REINS: begin
        ctrl.op           = spq_pkg::CELL_INSERT;
        count_d           = count_q + spq_pkg::CNT_W'(1);
        sum_d             = sum_q + spq_pkg::SUM_W'(cmd_q.item_key);
        done_d            = 1'b1;
        rsp_d.status      = spq_pkg::ST_OK;
        rsp_d.out_id      = cmd_q.item_id;
        rsp_d.out_key     = cmd_q.item_key;
        rsp_d.entry_count = count_d;
        rsp_d.key_total   = sum_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign busy_o = (state_q != spq_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::slot_t      left_i,
  input  logic                left_gt_i,
  input  spq_pkg::slot_t      right_i,
  input  logic                hit_i,
  output logic                hit_o,
  output logic                gt_o,
  output spq_pkg::slot_t      slot_o,
  output spq_pkg::slot_t      pick_o
);

  logic                      valid_q, valid_d;
  logic [spq_pkg::ID_W-1:0]  id_q, id_d;
  logic [spq_pkg::KEY_W-1:0] key_q, key_d;
  logic                      match;

  assign slot_o = '{valid: valid_q, id: id_q, key: key_q};
  // an empty cell counts as greater, so an entry with no greater key lands right after the tail
  assign gt_o   = !valid_q || (key_q > ctrl_i.key);
  assign match  = valid_q && (id_q == ctrl_i.id);
  assign hit_o  = hit_i | match;
  assign pick_o = (match && !hit_i) ? slot_o : '0;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    key_d   = key_q;
    case (ctrl_i.op)
      spq_pkg::CELL_INSERT: begin
        if (left_gt_i) begin
          valid_d = left_i.valid;
          id_d    = left_i.id;
          key_d   = left_i.key;
        end else if (gt_o) begin
          valid_d = 1'b1;
          id_d    = ctrl_i.id;
          key_d   = ctrl_i.key;
        end
      end
      spq_pkg::CELL_DELETE: begin
        // close the gap: take the right neighbor from the removed slot on
        if (hit_o) begin
          valid_d = right_i.valid;
          id_d    = right_i.id;
          key_d   = right_i.key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    key_q <= key_d;
  end

endmodule

### tb/sv/sorted_priority_queue_with_cancel_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_with_cancel_tb;
  import spq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  cmd_t cmd_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  sorted_priority_queue_with_cancel u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shape of a random phase: free mix of operations, a fill to capacity
  // followed by a drain, or raw noise over every field.
  typedef enum {PH_MIXED, PH_FILL, PH_NOISE} phase_e;

  // One row of the directed table. When pinned, rsp is the result typed in
  // by hand; otherwise the row is checked against the shadow queue.
  typedef struct {
    func_e       func;
    logic [15:0] id;
    logic [15:0] key;
    bit          pinned;
    rsp_t        rsp;
  } step_t;

  localparam int RANDOM_ITEMS = 850;

  // Shadow copy of the queue, kept in queue order.
  logic [ID_W-1:0]  shadow_id  [CAPACITY];
  logic [KEY_W-1:0] shadow_key [CAPACITY];
  int               shadow_n;
  logic [SUM_W-1:0] shadow_sum;

  rsp_t  pending_rsp_q [$];
  step_t dir_rows [$];
  int    sent_n;
  int    mismatch_n;

  // Place an entry behind every entry whose key is not greater.
  function automatic void shadow_place(logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    int pos;
    pos = shadow_n;
    while (pos > 0 && shadow_key[pos-1] > key) begin
      shadow_id[pos]  = shadow_id[pos-1];
      shadow_key[pos] = shadow_key[pos-1];
      pos--;
    end
    shadow_id[pos]  = id;
    shadow_key[pos] = key;
    shadow_n++;
    shadow_sum = shadow_sum + SUM_W'(key);
  endfunction

  // Remove the entry at pos and close the hole.
  function automatic void shadow_drop(int pos);
    int i;
    shadow_sum = shadow_sum - SUM_W'(shadow_key[pos]);
    for (i = pos; i + 1 < shadow_n; i++) begin
      shadow_id[i]  = shadow_id[i+1];
      shadow_key[i] = shadow_key[i+1];
    end
    shadow_n--;
  endfunction

  // Apply one command to the shadow queue and return the result it yields.
  function automatic rsp_t next_queue_rsp(cmd_t c);
    rsp_t r;
    int   pos;
    r        = '0;
    r.status = ST_OK;
    pos      = 0;
    case (c.func)
      FN_INSERT: begin
        if (shadow_n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_place(c.item_id, c.item_key);
          r.out_id  = c.item_id;
          r.out_key = c.item_key;
        end
      end
      FN_POP: begin
        if (shadow_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_id  = shadow_id[0];
          r.out_key = shadow_key[0];
          shadow_drop(0);
        end
      end
      default: begin
        // modify and cancel act on the first id match in queue order
        while (pos < shadow_n && shadow_id[pos] != c.item_id) pos++;
        if (pos >= shadow_n) begin
          r.status = ST_NOTFOUND;
        end else if (c.func == FN_MODIFY) begin
          shadow_drop(pos);
          shadow_place(c.item_id, c.item_key);
          r.out_id  = c.item_id;
          r.out_key = c.item_key;
        end else begin
          r.out_id  = shadow_id[pos];
          r.out_key = shadow_key[pos];
          shadow_drop(pos);
        end
      end
    endcase
    r.entry_count = CNT_W'(shadow_n);
    r.key_total   = shadow_sum;
    return r;
  endfunction

  function automatic cmd_t make_cmd(func_e f, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    cmd_t c;
    c.func     = f;
    c.item_id  = id;
    c.item_key = key;
    return c;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keys lean on the extremes and on a tiny range so equal keys collide.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Ids for insert come from a small pool half the time to make duplicates.
  function automatic logic [ID_W-1:0] pick_new_id();
    if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Ids for modify and cancel: mostly one that is held, else likely a miss.
  function automatic logic [ID_W-1:0] pick_lookup_id();
    int r;
    r = $urandom_range(0, 9);
    if (shadow_n > 0 && r < 6) return shadow_id[$urandom_range(0, shadow_n - 1)];
    if (r < 8) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic add_row(input func_e f, input logic [15:0] id, input logic [15:0] key,
                         input bit pin = 1'b0, input status_e st = ST_OK,
                         input logic [15:0] oid = '0, input logic [15:0] okey = '0,
                         input logic [CNT_W-1:0] cnt = '0, input logic [SUM_W-1:0] sum = '0);
    step_t row;
    row.func            = f;
    row.id              = id;
    row.key             = key;
    row.pinned          = pin;
    row.rsp.status      = st;
    row.rsp.out_id      = oid;
    row.rsp.out_key     = okey;
    row.rsp.entry_count = cnt;
    row.rsp.key_total   = sum;
    dir_rows.push_back(row);
  endtask

  // Raise start with the item, hold it until the block takes it, then
  // advance the shadow queue and queue the expected result. A nonzero gap
  // lowers start between items; with no gap start stays high for the next.
  task automatic push_item(input cmd_t c, input int gap, input bit pinned = 1'b0,
                           input rsp_t pin_rsp = '0);
    rsp_t want;
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    want = next_queue_rsp(c);
    pending_rsp_q.push_back(pinned ? pin_rsp : want);
    sent_n++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every pending result has come back.
  task automatic drain_pause();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_n++;
    end
  endtask

  // Result side: a result is taken at the edge ending its done cycle and
  // compared with the oldest pending expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, rsp_o);
        mismatch_n++;
      end else begin
        want = pending_rsp_q.pop_front();
        report_field("status", want.status, rsp_o.status);
        report_field("out_id", want.out_id, rsp_o.out_id);
        report_field("out_key", want.out_key, rsp_o.out_key);
        report_field("entry_count", want.entry_count, rsp_o.entry_count);
        report_field("key_total", want.key_total, rsp_o.key_total);
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    phase_e phase;
    bit     quiet;
    bit     max_keys;
    int     rand_goal;
    int     n;
    int     r;
    int     i;
    func_e  f;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cmd_i      = '0;
    shadow_n   = 0;
    shadow_sum = '0;
    sent_n     = 0;
    mismatch_n = 0;
    for (i = 0; i < CAPACITY; i++) begin
      shadow_id[i]  = '0;
      shadow_key[i] = '0;
    end

    // Directed table: empty-queue errors, extreme ids and keys, duplicate
    // ids, equal keys in arrival order, modify and cancel by first match.
    add_row(FN_POP,    16'h0000, 16'h0000, 1'b1, ST_EMPTY);
    add_row(FN_CANCEL, 16'h0005, 16'h0000, 1'b1, ST_NOTFOUND);
    add_row(FN_MODIFY, 16'hFFFF, 16'h1234, 1'b1, ST_NOTFOUND);
    add_row(FN_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK, 16'hFFFF, 16'hFFFF, 1, 22'h00FFFF);
    add_row(FN_INSERT, 16'h0000, 16'h0000, 1'b1, ST_OK, 16'h0000, 16'h0000, 2, 22'h00FFFF);
    add_row(FN_INSERT, 16'h0007, 16'h0064);
    add_row(FN_INSERT, 16'h0007, 16'h0064);
    add_row(FN_INSERT, 16'h0008, 16'h0064);
    add_row(FN_INSERT, 16'h00AA, 16'h5555);
    add_row(FN_MODIFY, 16'h0007, 16'h0001);
    add_row(FN_MODIFY, 16'h0007, 16'hFFFF);
    add_row(FN_CANCEL, 16'h0008, 16'hAAAA);
    add_row(FN_CANCEL, 16'h4321, 16'h0000);
    add_row(FN_CANCEL, 16'h0000, 16'h0000);
    add_row(FN_POP,    16'hFFFF, 16'hFFFF);
    add_row(FN_POP,    16'h0000, 16'h0000);
    add_row(FN_POP,    16'h0000, 16'h0000);
    add_row(FN_POP,    16'h0000, 16'h0000);
    add_row(FN_POP,    16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY);
    add_row(FN_MODIFY, 16'h0000, 16'hFFFF, 1'b1, ST_NOTFOUND);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      push_item(make_cmd(dir_rows[k].func, dir_rows[k].id, dir_rows[k].key),
                pick_gap(1'b0), dir_rows[k].pinned, dir_rows[k].rsp);
    end
    drain_pause();

    // Random phases. The first is a fill with the largest key so the key
    // sum reaches its top value and the full case is hit early.
    rand_goal = sent_n + RANDOM_ITEMS;
    n = 0;
    while (sent_n < rand_goal) begin
      r = $urandom_range(0, 99);
      if (n == 0 || r < 25) phase = PH_FILL;
      else if (r < 80) phase = PH_MIXED;
      else phase = PH_NOISE;
      max_keys = (n == 0);
      quiet    = ($urandom_range(0, 3) == 0);
      n++;

      case (phase)
        PH_FILL: begin
          // fill to capacity, bounce a few inserts off the full queue,
          // modify while full, drain by pop and cancel, then pop the empty queue
          while (shadow_n < CAPACITY) begin
            push_item(make_cmd(FN_INSERT, pick_new_id(), max_keys ? '1 : pick_key()),
                      pick_gap(quiet));
          end
          repeat ($urandom_range(1, 3)) begin
            push_item(make_cmd(FN_INSERT, pick_new_id(), pick_key()), pick_gap(quiet));
          end
          repeat ($urandom_range(2, 6)) begin
            push_item(make_cmd(FN_MODIFY, pick_lookup_id(), pick_key()), pick_gap(quiet));
          end
          while (shadow_n > 0) begin
            if ($urandom_range(0, 1) == 0) begin
              push_item(make_cmd(FN_POP, pick_new_id(), pick_key()), pick_gap(quiet));
            end else begin
              push_item(make_cmd(FN_CANCEL, pick_lookup_id(), pick_key()), pick_gap(quiet));
            end
          end
          push_item(make_cmd(FN_POP, pick_new_id(), pick_key()), pick_gap(quiet));
        end
        PH_MIXED: begin
          repeat ($urandom_range(30, 60)) begin
            r = $urandom_range(0, 99);
            if (r < 40) f = FN_INSERT;
            else if (r < 60) f = FN_POP;
            else if (r < 80) f = FN_MODIFY;
            else f = FN_CANCEL;
            push_item(make_cmd(f, (f == FN_INSERT) ? pick_new_id() : pick_lookup_id(),
                               pick_key()), pick_gap(quiet));
          end
        end
        default: begin
          repeat ($urandom_range(10, 25)) begin
            push_item(make_cmd(func_e'($urandom_range(0, 3)),
                               ID_W'($urandom_range(0, 16'hFFFF)),
                               KEY_W'($urandom_range(0, 16'hFFFF))), pick_gap(quiet));
          end
        end
      endcase

      // now and then let the block run dry between phases
      if ($urandom_range(0, 9) < 3) drain_pause();
    end

    // Wait out the last results, then keep watching for strays.
    drain_pause();
    repeat (8) @(posedge clk_i);

    if (mismatch_n == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
